/* hdl/noc_pkg.sv */
package noc_pkg;

	typedef enum logic [1:0] {
		OP_CHAR,
		OP_END,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] char_code;
		logic [9:0] entry_index;
		logic [4:0] char_position;
	} req_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_HIT,
		BK_READ
	} bk_state_t;

	localparam logic [2:0] ST_COUNTED   = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_READ_OK   = 3'd4;
	localparam logic [2:0] ST_READ_NONE = 3'd5;
	localparam logic [2:0] ST_CHAR      = 3'd6;
	localparam logic [2:0] ST_CLEARED   = 3'd7;

endpackage

/* hdl/noc_if.sv */
interface noc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] char_code;
	logic [9:0] entry_index;
	logic [4:0] char_position;

	modport source (output valid, req_type, char_code, entry_index, char_position,
		input ready);
	modport sink (input valid, req_type, char_code, entry_index, char_position,
		output ready);
endinterface

interface noc_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [9:0]  slot;
	logic [23:0] occurrences;
	logic [4:0]  key_length;
	logic [7:0]  name_char;

	modport source (output valid, status, slot, occurrences, key_length, name_char,
		input ready);
	modport sink (input valid, status, slot, occurrences, key_length, name_char,
		output ready);
endinterface

/* hdl/name_occurrence_counter.sv */
// Name occurrence counter.
// Requests arrive as beats on the req channel and every request produces
// exactly one result beat on the res channel, in request order.
// A character beat, a clear beat or an empty end of name is answered
// straight from the idle state, without a search of the table.
// A non-empty end of name searches the stored entries one per cycle until
// it finds a match or passes the last used entry. A read beat reads the
// memories as it leaves the queue and is answered from the read state.
// A two-beat queue lets req accept while the table is busy searching and
// while a result waits on res; when it is full, req.ready falls.
// When the receiver holds res.ready low, the result stays on res and the
// back end waits before it starts the next request.
// Reset empties the table and the name being collected; the stores need no
// clearing pass, so req.ready is high as soon as reset is released.
module name_occurrence_counter #(
	parameter int MAX_ENTRIES = 1024,
	parameter int KEY_CHARS   = 30,
	parameter int COUNT_BITS  = 24
) (
	input logic       clk,
	input logic       arst_n,
	noc_req_if.sink   req,
	noc_res_if.source res
);
	import noc_pkg::*;

	hs_t  q_hs;
	logic q_ready;
	req_t q_data;

	noc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_hs_o  (q_hs),
		.q_ready (q_ready),
		.q_data  (q_data)
	);

	noc_back #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_CHARS   (KEY_CHARS),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_hs    (q_hs),
		.q_ready (q_ready),
		.q_data  (q_data),
		.res     (res)
	);
endmodule

/* hdl/noc_front.sv */
module noc_front (
	input  logic          clk,
	input  logic          arst_n,
	noc_req_if.sink       req,
	output noc_pkg::hs_t  q_hs_o,
	input  logic          q_ready,
	output noc_pkg::req_t q_data
);
	import noc_pkg::*;

	req_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	req_t       item;

	always_comb begin
		item.op            = op_t'(req.req_type);
		item.char_code     = req.char_code;
		item.entry_index   = req.entry_index;
		item.char_position = req.char_position;
	end

	assign req.ready    = (fill_q != 2'd2);
	assign push         = req.valid && req.ready;
	assign q_hs_o.valid = (fill_q != 2'd0);
	assign q_hs_o.ready = q_ready;
	assign pop          = q_hs_o.valid && q_ready;
	assign q_data       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* hdl/noc_back.sv */
module noc_back #(
	parameter int MAX_ENTRIES = 1024,
	parameter int KEY_CHARS   = 30,
	parameter int COUNT_BITS  = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  noc_pkg::hs_t  q_hs,
	output logic          q_ready,
	input  noc_pkg::req_t q_data,
	noc_res_if.source     res
);
	import noc_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int UW = $clog2(MAX_ENTRIES + 1);
	localparam int LW = $clog2(KEY_CHARS + 1);

	typedef logic [KEY_CHARS-1:0][7:0] key_t;
	typedef logic [LW-1:0] len_t;
	typedef logic [COUNT_BITS-1:0] cnt_t;

	bk_state_t state_q, state_d;

	key_t            pk_q;
	len_t            plen_q;
	logic            pend_q;
	logic [UW-1:0]   used_q;
	logic [UW-1:0]   addr_q;
	logic            vld_s1;
	logic [AW-1:0]   addr_s1;
	logic [AW-1:0]   hit_addr_q;
	logic            idx_ok_q;
	logic [9:0]      idx_q;
	logic [4:0]      pos_q;

	key_t            key_mem [MAX_ENTRIES];
	len_t            len_mem [MAX_ENTRIES];
	cnt_t            cnt_mem [MAX_ENTRIES];
	key_t            key_rd;
	len_t            len_rd;
	cnt_t            cnt_rd;

	logic            res_valid_q;
	logic [2:0]      st_q;
	logic [9:0]      slot_q;
	logic [23:0]     occ_q;
	logic [4:0]      klen_q;
	logic [7:0]      nch_q;

	logic            out_free;
	logic            pop;
	logic            idx_ok;
	logic            match;
	logic            srch_rd;
	logic            miss;
	logic            full;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            take_char;
	len_t            plen_next;
	cnt_t            cnt_inc;
	logic [7:0]      rd_char;

	logic            emit;
	logic [2:0]      e_st;
	logic [9:0]      e_slot;
	logic [23:0]     e_occ;
	logic [4:0]      e_len;
	logic [7:0]      e_ch;
	logic            clr_pend;
	logic            ins_we;
	logic            cnt_we;
	logic [AW-1:0]   cnt_wa;
	cnt_t            cnt_wd;
	logic            start_srch;
	logic            do_clear;

	assign out_free  = !res_valid_q || res.ready;
	assign pop       = (state_q == BK_IDLE) && q_hs.valid && out_free;
	assign q_ready   = pop;
	assign idx_ok    = 32'(q_data.entry_index) < 32'(used_q);
	assign match     = (len_rd == plen_q) && (key_rd == pk_q);
	assign srch_rd   = (state_q == BK_SEARCH) && (addr_q < used_q) && !(vld_s1 && match);
	assign miss      = (state_q == BK_SEARCH) && !vld_s1 && (addr_q == used_q);
	assign full      = 32'(used_q) == MAX_ENTRIES;
	assign rd_en     = (pop && (q_data.op == OP_READ) && idx_ok) || srch_rd;
	assign rd_addr   = (state_q == BK_IDLE) ? AW'(q_data.entry_index) : AW'(addr_q);
	assign take_char = (q_data.char_code != 8'd0) && !pend_q
		&& (32'(plen_q) < KEY_CHARS);
	assign plen_next = take_char ? plen_q + len_t'(1) : plen_q;
	assign cnt_inc   = (cnt_rd == '1) ? cnt_rd : cnt_rd + cnt_t'(1);

	always_comb begin
		rd_char = 8'd0;
		for (int i = 0; i < KEY_CHARS; i++) begin
			if ((32'(pos_q) == i) && (32'(pos_q) < 32'(len_rd))) begin
				rd_char = key_rd[i];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop) begin
					if ((q_data.op == OP_END) && (plen_q != '0)) begin
						state_d = BK_SEARCH;
					end else if (q_data.op == OP_READ) begin
						state_d = BK_READ;
					end
				end
			end
			BK_SEARCH: begin
				if (vld_s1 && match) begin
					state_d = BK_HIT;
				end else if (miss) begin
					state_d = BK_IDLE;
				end
			end
			BK_HIT:  state_d = BK_IDLE;
			BK_READ: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		emit       = 1'b0;
		e_st       = ST_CHAR;
		e_slot     = 10'd0;
		e_occ      = 24'd0;
		e_len      = 5'd0;
		e_ch       = 8'd0;
		clr_pend   = 1'b0;
		ins_we     = 1'b0;
		cnt_we     = 1'b0;
		cnt_wa     = hit_addr_q;
		cnt_wd     = cnt_inc;
		start_srch = 1'b0;
		do_clear   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (pop) begin
					case (q_data.op)
						OP_CHAR: begin
							emit  = 1'b1;
							e_st  = ST_CHAR;
							e_len = 5'(plen_next);
						end
						OP_END: begin
							if (plen_q == '0) begin
								emit     = 1'b1;
								e_st     = ST_EMPTY;
								clr_pend = 1'b1;
							end else begin
								start_srch = 1'b1;
							end
						end
						OP_CLEAR: begin
							emit     = 1'b1;
							e_st     = ST_CLEARED;
							do_clear = 1'b1;
						end
						default: ;
					endcase
				end
			end
			BK_SEARCH: begin
				if (miss) begin
					emit     = 1'b1;
					clr_pend = 1'b1;
					e_len    = 5'(plen_q);
					if (full) begin
						e_st = ST_FULL;
					end else begin
						e_st   = ST_INSERTED;
						e_slot = 10'(used_q);
						e_occ  = 24'd1;
						ins_we = 1'b1;
						cnt_we = 1'b1;
						cnt_wa = AW'(used_q);
						cnt_wd = cnt_t'(1);
					end
				end
			end
			BK_HIT: begin
				emit     = 1'b1;
				clr_pend = 1'b1;
				e_st     = ST_COUNTED;
				e_slot   = 10'(hit_addr_q);
				e_occ    = 24'(cnt_inc);
				e_len    = 5'(plen_q);
				cnt_we   = 1'b1;
			end
			BK_READ: begin
				emit   = 1'b1;
				e_slot = idx_q;
				if (idx_ok_q) begin
					e_st  = ST_READ_OK;
					e_occ = 24'(cnt_rd);
					e_len = 5'(len_rd);
					e_ch  = rd_char;
				end else begin
					e_st = ST_READ_NONE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ins_we) begin
			key_mem[AW'(used_q)] <= pk_q;
			len_mem[AW'(used_q)] <= plen_q;
		end
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (rd_en) begin
			key_rd <= key_mem[rd_addr];
			len_rd <= len_mem[rd_addr];
			cnt_rd <= cnt_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (state_q == BK_SEARCH && vld_s1 && match) begin
			hit_addr_q <= addr_s1;
		end
		if (pop) begin
			idx_ok_q <= idx_ok;
			idx_q    <= q_data.entry_index;
			pos_q    <= q_data.char_position;
		end
		if (emit) begin
			st_q   <= e_st;
			slot_q <= e_slot;
			occ_q  <= e_occ;
			klen_q <= e_len;
			nch_q  <= e_ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			pk_q        <= '0;
			plen_q      <= '0;
			pend_q      <= 1'b0;
			used_q      <= '0;
			addr_q      <= '0;
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= srch_rd;
			if (start_srch) begin
				addr_q <= '0;
			end else if (srch_rd) begin
				addr_q <= addr_q + UW'(1);
			end
			if (pop && (q_data.op == OP_CHAR)) begin
				if (q_data.char_code == 8'd0) begin
					pend_q <= 1'b1;
				end
				if (take_char) begin
					for (int i = 0; i < KEY_CHARS; i++) begin
						if (32'(plen_q) == i) begin
							pk_q[i] <= q_data.char_code;
						end
					end
					plen_q <= plen_next;
				end
			end
			if (clr_pend) begin
				pk_q   <= '0;
				plen_q <= '0;
				pend_q <= 1'b0;
			end
			if (ins_we) begin
				used_q <= used_q + UW'(1);
			end else if (do_clear) begin
				used_q <= '0;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid       = res_valid_q;
	assign res.status      = st_q;
	assign res.slot        = slot_q;
	assign res.occurrences = occ_q;
	assign res.key_length  = klen_q;
	assign res.name_char   = nch_q;
endmodule

/* hdl/noc_checker.sv */
module noc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  status,
	input logic [9:0]  slot,
	input logic [23:0] occurrences,
	input logic [4:0]  key_length,
	input logic [7:0]  name_char
);
	import noc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status))
		else $error("result beat dropped while stalled");

	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_INSERTED) |-> (occurrences == 24'd1)
			&& (key_length != 5'd0) && (name_char == 8'd0))
		else $error("inserted entry with bad fields");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_CLEARED) |-> (slot == 10'd0)
			&& (occurrences == 24'd0) && (key_length == 5'd0))
		else $error("clear result with nonzero fields");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_COUNTED) |-> (occurrences != 24'd0)
			&& (key_length != 5'd0))
		else $error("counted entry with zero count or length");
endmodule

bind name_occurrence_counter noc_checker u_noc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.status      (res.status),
	.slot        (res.slot),
	.occurrences (res.occurrences),
	.key_length  (res.key_length),
	.name_char   (res.name_char)
);

/* bench/name_occurrence_counter_tb.sv */
`timescale 1ns / 100ps

module name_occurrence_counter_tb;
	import noc_pkg::*;

	localparam int ENTRIES = 1024;
	localparam int KEYLEN = 30;
	localparam logic [23:0] COUNT_TOP = 24'hFFFFFF;
	localparam int QUIET_LIMIT = 20000;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  slot;
		logic [23:0] occurrences;
		logic [4:0]  key_length;
		logic [7:0]  name_char;
	} result_t;

	typedef struct {
		op_t        op;
		logic [7:0] ch;
		logic [9:0] idx;
		logic [4:0] pos;
		bit         typed;
		result_t    want;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	noc_req_if req ();
	noc_res_if res ();

	name_occurrence_counter uut (.clk(clk), .arst_n(arst_n), .req(req.sink), .res(res.source));

	logic [7:0]  names [ENTRIES][KEYLEN];
	logic [4:0]  lengths [ENTRIES];
	logic [23:0] counts [ENTRIES];
	int          used;
	logic [7:0]  pend_key [KEYLEN];
	int          pend_len;
	bit          pend_ended;

	result_t     result_q [$];
	bit          typed_q [$];
	result_t     typed_want_q [$];
	int          failures = 0;
	int          quiet = 0;
	bit          send_idle = 1;
	bit          recv_idle = 1;
	int          stall_left = 0;
	int          sent = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic result_t tally(op_t op, logic [7:0] ch, logic [9:0] idx,
			logic [4:0] pos);
		result_t r;
		bit hit;
		r = '0;
		hit = 0;
		case (op)
			OP_CHAR: begin
				if (ch == 0)
					pend_ended = 1;
				else if (!pend_ended && pend_len < KEYLEN) begin
					pend_key[pend_len] = ch;
					pend_len++;
				end
				r.status = ST_CHAR;
				r.key_length = 5'(pend_len);
			end
			OP_END: begin
				if (pend_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (int e = 0; e < used && !hit; e++) begin
						if (lengths[e] == pend_len) begin
							hit = 1;
							for (int k = 0; k < pend_len; k++)
								if (names[e][k] != pend_key[k])
									hit = 0;
							if (hit) begin
								if (counts[e] != COUNT_TOP)
									counts[e]++;
								r.status = ST_COUNTED;
								r.slot = 10'(e);
								r.occurrences = counts[e];
								r.key_length = 5'(pend_len);
							end
						end
					end
					if (!hit && used < ENTRIES) begin
						names[used] = pend_key;
						lengths[used] = 5'(pend_len);
						counts[used] = 24'd1;
						r.status = ST_INSERTED;
						r.slot = 10'(used);
						r.occurrences = 24'd1;
						r.key_length = 5'(pend_len);
						used++;
					end else if (!hit) begin
						r.status = ST_FULL;
						r.key_length = 5'(pend_len);
					end
				end
				foreach (pend_key[k])
					pend_key[k] = 0;
				pend_len = 0;
				pend_ended = 0;
			end
			OP_READ: begin
				r.slot = idx;
				if (idx < used) begin
					r.status = ST_READ_OK;
					r.occurrences = counts[idx];
					r.key_length = lengths[idx];
					if (pos < lengths[idx])
						r.name_char = names[idx][pos];
				end else begin
					r.status = ST_READ_NONE;
				end
			end
			default: begin
				used = 0;
				r.status = ST_CLEARED;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		result_t got;
		result_t want;
		result_t typed_want;
		bit typed;
		if (res.valid && res.ready) begin
			got = {res.status, res.slot, res.occurrences, res.key_length, res.name_char};
			if (result_q.size() == 0) begin
				$error("result beat with nothing expected: status %0d", got.status);
				failures++;
			end else begin
				want = result_q.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					failures++;
				end
				if (got.slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, got.slot);
					failures++;
				end
				if (got.occurrences !== want.occurrences) begin
					$error("occurrences: expected %0d, got %0d", want.occurrences,
						got.occurrences);
					failures++;
				end
				if (got.key_length !== want.key_length) begin
					$error("key_length: expected %0d, got %0d", want.key_length,
						got.key_length);
					failures++;
				end
				if (got.name_char !== want.name_char) begin
					$error("name_char: expected %0d, got %0d", want.name_char,
						got.name_char);
					failures++;
				end
			end
		end
		if (req.valid && req.ready) begin
			want = tally(op_t'(req.req_type), req.char_code, req.entry_index,
				req.char_position);
			typed = typed_q.pop_front();
			typed_want = typed_want_q.pop_front();
			result_q.push_back(typed ? typed_want : want);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || !recv_idle) begin
			res.ready <= 1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			res.ready <= 0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			res.ready <= 0;
			stall_left <= $urandom_range(0, 8);
		end else begin
			res.ready <= 1;
		end
	end

	task automatic send(op_t op, logic [7:0] ch, logic [9:0] idx, logic [4:0] pos,
			bit typed = 0, result_t want = '0);
		int gap;
		gap = 0;
		if (send_idle && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 9);
		if (gap > 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		typed_q.push_back(typed);
		typed_want_q.push_back(want);
		req.valid <= 1;
		req.req_type <= op;
		req.char_code <= ch;
		req.entry_index <= idx;
		req.char_position <= pos;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_name(int len, bit narrow);
		logic [7:0] c;
		for (int k = 0; k < len; k++) begin
			c = narrow ? 8'(97 + $urandom_range(0, 2)) : 8'($urandom_range(1, 255));
			if ($urandom_range(0, 30) == 0)
				c = 0;
			send(OP_CHAR, c, 10'($urandom), 5'($urandom_range(0, 29)));
		end
		send(OP_END, 8'($urandom), 10'($urandom), 5'($urandom_range(0, 29)));
	endtask

	task automatic random_mix(int count);
		int pick;
		while (count > 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_name($urandom_range(0, 99) < 90 ? $urandom_range(1, 4) :
					$urandom_range(5, 34), $urandom_range(0, 2) != 0);
			end else if (pick < 92) begin
				send(OP_READ, 8'($urandom), $urandom_range(0, 5) == 0 ? 10'($urandom) :
					10'($urandom_range(0, used + 1)), 5'($urandom_range(0, 29)));
			end else if (pick < 97) begin
				send(OP_END, 8'($urandom), 10'($urandom), 5'($urandom));
			end else begin
				send(OP_CLEAR, 8'($urandom), 10'($urandom), 5'($urandom_range(0, 29)));
			end
			count--;
		end
	endtask

	task automatic drain();
		req.valid <= 0;
		@(posedge clk);
		while (result_q.size() != 0)
			@(posedge clk);
	endtask

	row_t rows [] = '{
		'{OP_READ, 8'h00, 10'd0, 5'd0, 1, '{ST_READ_NONE, 10'd0, 24'd0, 5'd0, 8'd0}},
		'{OP_READ, 8'hFF, 10'd1023, 5'd29, 1,
			'{ST_READ_NONE, 10'd1023, 24'd0, 5'd0, 8'd0}},
		'{OP_END, 8'h00, 10'd0, 5'd0, 1, '{ST_EMPTY, 10'd0, 24'd0, 5'd0, 8'd0}},
		'{OP_CLEAR, 8'h00, 10'd0, 5'd0, 1, '{ST_CLEARED, 10'd0, 24'd0, 5'd0, 8'd0}},
		'{OP_CHAR, 8'h01, 10'd0, 5'd0, 1, '{ST_CHAR, 10'd0, 24'd0, 5'd1, 8'd0}},
		'{OP_CHAR, 8'hFF, 10'd0, 5'd0, 1, '{ST_CHAR, 10'd0, 24'd0, 5'd2, 8'd0}},
		'{OP_END, 8'h00, 10'd0, 5'd0, 1, '{ST_INSERTED, 10'd0, 24'd1, 5'd2, 8'd0}},
		'{OP_CHAR, 8'h01, 10'd0, 5'd0, 0, '0},
		'{OP_CHAR, 8'hFF, 10'd0, 5'd0, 0, '0},
		'{OP_END, 8'h00, 10'd0, 5'd0, 1, '{ST_COUNTED, 10'd0, 24'd2, 5'd2, 8'd0}},
		'{OP_READ, 8'h00, 10'd0, 5'd1, 1, '{ST_READ_OK, 10'd0, 24'd2, 5'd2, 8'hFF}},
		'{OP_READ, 8'h00, 10'd0, 5'd2, 1, '{ST_READ_OK, 10'd0, 24'd2, 5'd2, 8'h00}},
		'{OP_CHAR, 8'h42, 10'd0, 5'd0, 0, '0},
		'{OP_CHAR, 8'h00, 10'd0, 5'd0, 1, '{ST_CHAR, 10'd0, 24'd0, 5'd1, 8'd0}},
		'{OP_CHAR, 8'h43, 10'd0, 5'd0, 1, '{ST_CHAR, 10'd0, 24'd0, 5'd1, 8'd0}},
		'{OP_END, 8'h00, 10'd0, 5'd0, 1, '{ST_INSERTED, 10'd1, 24'd1, 5'd1, 8'd0}},
		'{OP_CHAR, 8'h78, 10'd0, 5'd0, 0, '0},
		'{OP_CLEAR, 8'h00, 10'd0, 5'd0, 1, '{ST_CLEARED, 10'd0, 24'd0, 5'd0, 8'd0}},
		'{OP_END, 8'h00, 10'd0, 5'd0, 1, '{ST_INSERTED, 10'd0, 24'd1, 5'd1, 8'd0}},
		'{OP_READ, 8'h00, 10'd1, 5'd0, 1, '{ST_READ_NONE, 10'd1, 24'd0, 5'd0, 8'd0}},
		'{OP_READ, 8'h00, 10'd0, 5'd0, 0, '0}
	};

	initial begin
		req.valid = 0;
		req.req_type = OP_CHAR;
		req.char_code = 0;
		req.entry_index = 0;
		req.char_position = 0;
		used = 0;
		pend_len = 0;
		pend_ended = 0;
		foreach (pend_key[k])
			pend_key[k] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i])
			send(rows[i].op, rows[i].ch, rows[i].idx, rows[i].pos, rows[i].typed,
				rows[i].want);

		// Names longer than the key are cut to the key length before they are stored.
		send_name(34, 0);
		for (int k = 0; k < 31; k++)
			send(OP_CHAR, 8'h5A, 10'd0, 5'd0);
		send(OP_END, 8'h00, 10'd0, 5'd0);
		send(OP_READ, 8'h00, 10'd1, 5'd29);

		random_mix(40);
		drain();
		random_mix(40);
		random_mix(25);

		send_idle = 0;
		recv_idle = 0;
		random_mix(20);

		drain();
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
hdl/noc_pkg.sv
hdl/noc_if.sv
hdl/noc_front.sv
hdl/noc_back.sv
hdl/name_occurrence_counter.sv
hdl/noc_checker.sv
bench/name_occurrence_counter_tb.sv
